### hw/rtl/tcw_pkg.sv
// Package for the text console writer: item and result types, mode,
// character and register codes, sequencer states.
// No dependencies.
package tcw_pkg;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int BYTE_W = 8;

    typedef logic [1:0]        t_mode;
    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [15:0]       t_cell;
    typedef logic [0:0]        t_cfg_index;

    localparam t_mode MODE_PUT   = 2'd0;
    localparam t_mode MODE_CLEAR = 2'd1;
    localparam t_mode MODE_READ  = 2'd2;

    localparam t_byte CH_NEWLINE   = 8'd10;
    localparam t_byte CH_BACKSPACE = 8'd8;
    localparam t_byte CH_SPACE     = 8'd32;

    localparam t_byte GLYPH_RESET = 8'h0F;
    localparam t_byte BLANK_RESET = 8'h07;

    localparam t_cfg_index CFG_GLYPH = 1'b0;
    localparam t_cfg_index CFG_BLANK = 1'b1;

    typedef struct packed {
        t_mode             mode;
        t_byte             char_code;
        logic [COL_W-1:0]  cell_column;
        logic [ROW_W-1:0]  cell_row;
    } t_item;

    typedef struct packed {
        t_byte             read_char;
        t_byte             read_attr;
        logic [COL_W-1:0]  cursor_column;
        logic [ROW_W-1:0]  cursor_row;
        logic              did_scroll;
    } t_result;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_READ,
        S_CLEAR,
        S_SCROLL,
        S_BOTTOM,
        S_DONE
    } t_state;

endpackage

### hw/rtl/tcw_item_if.sv
// Input channel of the text console writer: valid, ready and item fields.
// Depends on tcw_pkg.
interface tcw_item_if;
    import tcw_pkg::*;

    logic                  valid;
    logic                  ready;
    t_mode                 mode;
    t_byte                 char_code;
    logic [COL_W-1:0]      cell_column;
    logic [ROW_W-1:0]      cell_row;

    modport source (output valid, mode, char_code, cell_column, cell_row, input ready);
    modport sink   (input valid, mode, char_code, cell_column, cell_row, output ready);
endinterface

### hw/rtl/tcw_result_if.sv
// Result channel of the text console writer: valid, ready and result fields.
// Depends on tcw_pkg.
interface tcw_result_if;
    import tcw_pkg::*;

    logic                  valid;
    logic                  ready;
    t_byte                 read_char;
    t_byte                 read_attr;
    logic [COL_W-1:0]      cursor_column;
    logic [ROW_W-1:0]      cursor_row;
    logic                  did_scroll;

    modport source (output valid, read_char, read_attr, cursor_column, cursor_row,
                    did_scroll, input ready);
    modport sink   (input valid, read_char, read_attr, cursor_column, cursor_row,
                    did_scroll, output ready);
endinterface

### hw/rtl/tcw_screen_ram.sv
// Screen store: one write port, one registered read port, 16-bit cells.
// Depends on tcw_pkg.
module tcw_screen_ram #(
    parameter int DEPTH = 2000,
    parameter int AW    = 11
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  tcw_pkg::t_cell  i_wdata,
    input  logic            i_re,
    input  logic [AW-1:0]   i_raddr,
    output tcw_pkg::t_cell  o_rdata
);
    import tcw_pkg::*;

    t_cell r_mem [DEPTH];
    t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/tcw_ctrl.sv
// Sequencer of the text console writer: cursor, cell address unit and the
// sweep counter for reset fill, clear and scroll. Depends on tcw_pkg.
module tcw_ctrl #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int AW      = 11
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  tcw_pkg::t_item    i_item,
    input  tcw_pkg::t_byte    i_glyph_attr,
    input  tcw_pkg::t_byte    i_blank_attr,
    input  logic              i_out_free,
    output logic              o_push,
    output tcw_pkg::t_result  o_res,
    output logic              o_we,
    output logic [AW-1:0]     o_waddr,
    output tcw_pkg::t_cell    o_wdata,
    output logic              o_re,
    output logic [AW-1:0]     o_raddr,
    input  tcw_pkg::t_cell    i_rdata
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int SW    = $clog2(CELLS + 1);

    t_state           r_state, n_state;
    logic [CW-1:0]    r_col, n_col;
    logic [RW-1:0]    r_row, n_row;
    t_byte            r_rc, n_rc;
    t_byte            r_ra, n_ra;
    logic             r_scr, n_scr;
    t_mode            r_mode, n_mode;
    t_byte            r_ch, n_ch;
    logic [COL_W-1:0] r_icol, n_icol;
    logic [ROW_W-1:0] r_irow, n_irow;
    logic [SW-1:0]    r_sa, n_sa;
    logic             r_pv, n_pv;
    logic [AW-1:0]    r_pa, n_pa;

    logic [CW:0]      col_inc;
    logic [RW:0]      row_inc;
    logic             col_wrap, row_wrap;
    logic             is_nl, is_bs, rd_in, need_scroll, exec_ends;
    logic             sa_last, sa_end;
    logic [CW-1:0]    a_col;
    logic [RW-1:0]    a_row;
    logic [AW-1:0]    a_addr;

    assign col_inc  = {1'b0, r_col} + 1'b1;
    assign row_inc  = {1'b0, r_row} + 1'b1;
    assign col_wrap = col_inc == (CW+1)'(COLUMNS);
    assign row_wrap = row_inc == (RW+1)'(ROWS);
    assign is_nl    = r_ch == CH_NEWLINE;
    assign is_bs    = r_ch == CH_BACKSPACE;
    assign rd_in    = (r_icol < COLUMNS) && (r_irow < ROWS);
    assign need_scroll = (r_mode == MODE_PUT) && row_wrap && (is_nl || (!is_bs && col_wrap));
    assign exec_ends   = !need_scroll && (r_mode != MODE_CLEAR) &&
                         !((r_mode == MODE_READ) && rd_in);
    assign sa_last  = r_sa == SW'(CELLS - 1);
    assign sa_end   = r_sa == SW'(CELLS);

    always_comb begin
        a_col = r_col;
        a_row = r_row;
        if (r_mode == MODE_READ) begin
            a_col = CW'(r_icol);
            a_row = RW'(r_irow);
        end else if (is_bs) begin
            a_col = n_col;
            a_row = n_row;
        end
    end

    assign a_addr  = AW'(a_row) * AW'(COLUMNS) + AW'(a_col);
    assign o_raddr = (r_state == S_SCROLL) ? r_sa[AW-1:0] : a_addr;
    assign o_in_ready = r_state == S_IDLE;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT:   if (sa_last) n_state = S_IDLE;
            S_IDLE:   if (i_in_valid) n_state = S_EXEC;
            S_EXEC: begin
                if (need_scroll) begin
                    n_state = S_SCROLL;
                end else if (r_mode == MODE_CLEAR) begin
                    n_state = S_CLEAR;
                end else if ((r_mode == MODE_READ) && rd_in) begin
                    n_state = S_READ;
                end else begin
                    n_state = i_out_free ? S_IDLE : S_DONE;
                end
            end
            S_READ:   n_state = i_out_free ? S_IDLE : S_DONE;
            S_CLEAR:  if (sa_last) n_state = S_DONE;
            S_SCROLL: if (sa_end && r_pv) n_state = S_BOTTOM;
            S_BOTTOM: if (sa_last) n_state = S_DONE;
            S_DONE:   if (i_out_free) n_state = S_IDLE;
            default:  n_state = S_INIT;
        endcase
    end

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_rc   = r_rc;
        n_ra   = r_ra;
        n_scr  = r_scr;
        n_mode = r_mode;
        n_ch   = r_ch;
        n_icol = r_icol;
        n_irow = r_irow;
        n_sa   = r_sa;
        n_pv   = r_pv;
        n_pa   = r_pa;
        o_we    = 1'b0;
        o_waddr = a_addr;
        o_wdata = {i_blank_attr, CH_SPACE};
        o_re    = 1'b0;
        o_push  = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_we    = 1'b1;
                o_waddr = r_sa[AW-1:0];
                o_wdata = {BLANK_RESET, CH_SPACE};
                n_sa    = r_sa + 1'b1;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode = i_item.mode;
                    n_ch   = i_item.char_code;
                    n_icol = i_item.cell_column;
                    n_irow = i_item.cell_row;
                    n_rc   = '0;
                    n_ra   = '0;
                    n_scr  = 1'b0;
                end
            end
            S_EXEC: begin
                case (r_mode)
                    MODE_PUT: begin
                        if (is_nl) begin
                            n_col = '0;
                            if (!row_wrap) n_row = row_inc[RW-1:0];
                        end else if (is_bs) begin
                            if (r_col != '0) begin
                                n_col = r_col - 1'b1;
                                o_we  = 1'b1;
                            end else if (r_row != '0) begin
                                n_row = r_row - 1'b1;
                                n_col = CW'(COLUMNS - 1);
                                o_we  = 1'b1;
                            end
                        end else begin
                            o_we    = 1'b1;
                            o_wdata = {i_glyph_attr, r_ch};
                            if (col_wrap) begin
                                n_col = '0;
                                if (!row_wrap) n_row = row_inc[RW-1:0];
                            end else begin
                                n_col = col_inc[CW-1:0];
                            end
                        end
                        if (need_scroll) begin
                            n_scr = 1'b1;
                            n_sa  = SW'(COLUMNS);
                            n_pv  = 1'b0;
                        end
                    end
                    MODE_CLEAR: begin
                        n_col = '0;
                        n_row = '0;
                        n_sa  = '0;
                    end
                    MODE_READ: o_re = rd_in;
                    default: ;
                endcase
                o_push = exec_ends && i_out_free;
            end
            S_READ: begin
                n_rc   = i_rdata[7:0];
                n_ra   = i_rdata[15:8];
                o_push = i_out_free;
            end
            S_CLEAR: begin
                o_we    = 1'b1;
                o_waddr = r_sa[AW-1:0];
                n_sa    = r_sa + 1'b1;
            end
            S_SCROLL: begin
                o_waddr = r_pa;
                o_wdata = i_rdata;
                o_we    = r_pv;
                if (!sa_end) begin
                    o_re = 1'b1;
                    n_sa = r_sa + 1'b1;
                    n_pv = 1'b1;
                    n_pa = AW'(r_sa - SW'(COLUMNS));
                end else begin
                    n_pv = 1'b0;
                    n_sa = SW'(CELLS - COLUMNS);
                end
            end
            S_BOTTOM: begin
                o_we    = 1'b1;
                o_waddr = r_sa[AW-1:0];
                n_sa    = r_sa + 1'b1;
            end
            S_DONE:  o_push = i_out_free;
            default: ;
        endcase
    end

    always_comb begin
        o_res.read_char     = n_rc;
        o_res.read_attr     = n_ra;
        o_res.cursor_column = COL_W'(n_col);
        o_res.cursor_row    = ROW_W'(n_row);
        o_res.did_scroll    = n_scr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_col   <= '0;
            r_row   <= '0;
            r_sa    <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_row   <= n_row;
            r_sa    <= n_sa;
            r_pv    <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rc   <= n_rc;
        r_ra   <= n_ra;
        r_scr  <= n_scr;
        r_mode <= n_mode;
        r_ch   <= n_ch;
        r_icol <= n_icol;
        r_irow <= n_irow;
        r_pa   <= n_pa;
    end
endmodule

### hw/rtl/text_console_writer.sv
// Text console writer top level: configuration registers, result register,
// sequencer and screen store. Depends on tcw_pkg, tcw_item_if, tcw_result_if,
// tcw_screen_ram and tcw_ctrl.
//
// Usage:
//   i_item carries one command per item (put character, clear, read cell);
//   o_result returns one result per item with the cursor after the command.
//   i_cfg_we/i_cfg_index/i_cfg_data write the glyph and blank attributes;
//   write them only while no item is in flight.
// Steps per item, accept to next ready (the result loads as ready returns):
//   put character, newline, backspace, unused mode: an execute state;
//   read cell: execute, then read state (registered read port of the store);
//   scroll: execute, then one cell moved up a row per cycle through the
//   store's separate read and write ports, one blank write per column, done;
//   clear: execute, then one cell written per cycle, then done.
//   i_item.ready is high only while the sequencer is idle.
// Reset: the cursor goes home and a fill pass writes a blank with attribute
//   0x07 to every cell before the first item is taken.
// Stall: a result waits in the output register; the next item is still
//   accepted and its result is held in the sequencer until the register frees.
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    tcw_item_if.sink              i_item,
    tcw_result_if.source          o_result,
    input  logic                  i_cfg_we,
    input  tcw_pkg::t_cfg_index   i_cfg_index,
    input  tcw_pkg::t_byte        i_cfg_data
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    t_byte   r_glyph, r_blank;
    logic    r_ovalid;
    t_result r_ores;

    t_item   item;
    t_result res;
    logic    in_ready, push, out_free;
    logic    we, re;
    logic [AW-1:0] waddr, raddr;
    t_cell   wdata, rdata;

    assign item.mode        = i_item.mode;
    assign item.char_code   = i_item.char_code;
    assign item.cell_column = i_item.cell_column;
    assign item.cell_row    = i_item.cell_row;
    assign i_item.ready     = in_ready;

    assign out_free = !r_ovalid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph <= GLYPH_RESET;
            r_blank <= BLANK_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GLYPH: r_glyph <= i_cfg_data;
                CFG_BLANK: r_blank <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (push) begin
            r_ovalid <= 1'b1;
        end else if (o_result.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ores <= res;
        end
    end

    assign o_result.valid         = r_ovalid;
    assign o_result.read_char     = r_ores.read_char;
    assign o_result.read_attr     = r_ores.read_attr;
    assign o_result.cursor_column = r_ores.cursor_column;
    assign o_result.cursor_row    = r_ores.cursor_row;
    assign o_result.did_scroll    = r_ores.did_scroll;

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .AW      (AW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_item.valid),
        .o_in_ready   (in_ready),
        .i_item       (item),
        .i_glyph_attr (r_glyph),
        .i_blank_attr (r_blank),
        .i_out_free   (out_free),
        .o_push       (push),
        .o_res        (res),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_re         (re),
        .o_raddr      (raddr),
        .i_rdata      (rdata)
    );

    tcw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );
endmodule
